// File: rtl/fbba_pkg.sv
// Shared constants, opcodes and controller/datapath handshake types.
`timescale 1ns / 1ps
package fbba_pkg;

   localparam int MAP_BITS_DEF  = 32768;
   localparam int WORD_BITS_DEF = 32;

   localparam int IDX_W = 15;   // block index and free index width
   localparam int CNT_W = 16;   // block_count register width

   localparam logic [CNT_W-1:0] COUNT_RESET = 16'd32768;

   localparam logic OP_TOGGLE = 1'b0;
   localparam logic OP_FIND   = 1'b1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;       // request taken, capture block index
      logic clear_step;   // zero one bitmap word
      logic tg_div;       // toggle: word index from block index
      logic tg_read;      // toggle: read the word, form bit offset
      logic tg_write;     // toggle: write back flipped word
      logic scan_start;   // find: reset scan pointers, latch limit
      logic scan_run;     // find: issue next word, evaluate previous
      logic load_out;     // move find result into response register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic clear_last;   // last word of the clearing pass
      logic scan_done;    // find has its answer
      logic out_free;     // response register can take a result
   } status_type;

endpackage

// File: rtl/fbba_if.sv
// Request, response and register-write channel interfaces.
`timescale 1ns / 1ps
interface fbba_req_if;
   import fbba_pkg::*;
   logic             valid;
   logic             ready;
   logic             opcode;
   logic [IDX_W-1:0] block_index;

   modport source (output valid, output opcode, output block_index, input ready);
   modport sink   (input valid, input opcode, input block_index, output ready);
endinterface

interface fbba_rsp_if;
   import fbba_pkg::*;
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] free_index;
   logic             found;

   modport source (output valid, output free_index, output found, input ready);
   modport sink   (input valid, input free_index, input found, output ready);
endinterface

interface fbba_csr_if;
   import fbba_pkg::*;
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] block_count;

   modport source (output valid, output block_count, input ready);
   modport sink   (input valid, input block_count, output ready);
endinterface

// File: rtl/fbba_ctrl.sv
// Controller state machine: clearing pass, toggle sequence, scan, result hand-off.
`timescale 1ns / 1ps
module fbba_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_opcode,
   output logic                 req_ready,
   input  fbba_pkg::status_type status,
   output fbba_pkg::cmd_type    cmd
);
   import fbba_pkg::*;

   typedef enum logic [6:0] {
      ST_CLEAR    = 7'b0000001,
      ST_IDLE     = 7'b0000010,
      ST_TG_DIV   = 7'b0000100,
      ST_TG_READ  = 7'b0001000,
      ST_TG_WRITE = 7'b0010000,
      ST_SCAN     = 7'b0100000,
      ST_FLUSH    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_opcode == OP_FIND) begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end else begin
                  state_in = ST_TG_DIV;
               end
            end
         end
         ST_TG_DIV: begin
            cmd.tg_div = 1'b1;
            state_in   = ST_TG_READ;
         end
         ST_TG_READ: begin
            cmd.tg_read = 1'b1;
            state_in    = ST_TG_WRITE;
         end
         ST_TG_WRITE: begin
            cmd.tg_write = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (status.scan_done) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

// File: rtl/fbba_dp.sv
// Datapath: bitmap memory, toggle read-modify-write, word scan, response register.
`timescale 1ns / 1ps
module fbba_dp #(
   parameter int MAP_BITS  = fbba_pkg::MAP_BITS_DEF,
   parameter int WORD_BITS = fbba_pkg::WORD_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  fbba_pkg::cmd_type           cmd,
   output fbba_pkg::status_type        status,
   input  logic [fbba_pkg::IDX_W-1:0]  req_block_index,
   input  logic                        csr_valid,
   input  logic [fbba_pkg::CNT_W-1:0]  csr_block_count,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [fbba_pkg::IDX_W-1:0]  rsp_free_index,
   output logic                        rsp_found
);
   import fbba_pkg::*;

   localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int SPAN_W    = BIT_W + 1;
   // word index = block / WORD_BITS by reciprocal multiply, exact for IDX_W-bit blocks
   localparam int SH        = IDX_W + BIT_W;
   localparam int RECIP_W   = SH - 2;
   localparam int RECIP     = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
   localparam int PROD_W    = IDX_W + RECIP_W;
   localparam int Q_W       = IDX_W - BIT_W + 1;
   localparam int POS_W     = $clog2((MAP_WORDS + 2) * WORD_BITS + 1);
   localparam int LIM_W     = (POS_W > CNT_W) ? POS_W : CNT_W;

   localparam logic [LIM_W-1:0]  MAP_BITS_L  = LIM_W'(MAP_BITS);
   localparam logic [LIM_W-1:0]  WORD_BITS_L = LIM_W'(WORD_BITS);
   localparam logic [IDX_W-1:0]  WORD_BITS_I = IDX_W'(WORD_BITS);
   localparam logic [AW:0]       MAP_WORDS_A = (AW + 1)'(MAP_WORDS);
   localparam logic [AW-1:0]     LAST_WORD   = AW'(MAP_WORDS - 1);

   // bitmap store, zeroed by the clearing pass
   logic [WORD_BITS-1:0] mem [MAP_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_en, wr_en;
   logic [AW-1:0]        rd_addr, wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   logic [CNT_W-1:0] block_count_ff;
   logic [AW-1:0]    clr_addr_ff;

   // toggle
   logic [IDX_W-1:0]  blk_ff;
   logic [Q_W-1:0]    q_ff;
   logic [BIT_W-1:0]  rem_ff;
   logic [PROD_W-1:0] prod;
   logic [IDX_W-1:0]  q_times_w;
   logic              blk_ok;

   // scan
   logic [AW:0]        iss_addr_ff;
   logic [LIM_W-1:0]   iss_base_ff, ev_base_ff, limit_ff, limit_in, cnt8, diff;
   logic               ev_valid_ff;
   logic [SPAN_W-1:0]  span;
   logic [WORD_BITS-1:0] span_mask, free_bits;
   logic [BIT_W-1:0]   pos;
   logic               in_range, hit, done;
   logic [LIM_W-1:0]   hit_pos;
   logic [IDX_W-1:0]   res_index_ff;
   logic               res_found_ff;

   logic               rsp_valid_ff;
   logic [IDX_W-1:0]   rsp_index_ff;
   logic               rsp_found_ff;

   // ---------------- memory ----------------
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign blk_ok = (32'(blk_ff) < 32'(MAP_BITS));

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = AW'(q_ff);
      if (cmd.tg_read) begin
         rd_en = blk_ok;
      end else if (cmd.scan_run) begin
         rd_en   = (iss_addr_ff < MAP_WORDS_A);
         rd_addr = iss_addr_ff[AW-1:0];
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = AW'(q_ff);
      wr_data = rd_data_ff ^ (WORD_BITS'(1) << rem_ff);
      if (cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else if (cmd.tg_write) begin
         wr_en = blk_ok;
      end
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff    <= '0;
         block_count_ff <= COUNT_RESET;
         rsp_valid_ff   <= 1'b0;
         ev_valid_ff    <= 1'b0;
      end else begin
         if (cmd.clear_step) clr_addr_ff <= clr_addr_ff + AW'(1);
         if (csr_valid) block_count_ff <= csr_block_count;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.scan_start) begin
            ev_valid_ff <= 1'b0;
         end else if (cmd.scan_run) begin
            ev_valid_ff <= 1'b1;
         end
      end
   end

   // ---------------- toggle path ----------------
   assign prod      = PROD_W'(blk_ff) * PROD_W'(RECIP);
   assign q_times_w = IDX_W'(q_ff) * WORD_BITS_I;

   always_ff @(posedge clock) begin
      if (cmd.accept)  blk_ff <= req_block_index;
      if (cmd.tg_div)  q_ff   <= Q_W'(prod >> SH);
      if (cmd.tg_read) rem_ff <= BIT_W'(blk_ff - q_times_w);
   end

   // ---------------- scan path ----------------
   assign cnt8     = LIM_W'({block_count_ff[CNT_W-1:3], 3'b000});
   assign limit_in = (cnt8 > MAP_BITS_L) ? MAP_BITS_L : cnt8;

   assign in_range = (ev_base_ff < limit_ff);
   assign diff     = limit_ff - ev_base_ff;
   assign span     = (diff > WORD_BITS_L) ? SPAN_W'(WORD_BITS) : SPAN_W'(diff);

   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         span_mask[i] = (SPAN_W'(i) < span);
      end
   end

   assign free_bits = ~rd_data_ff & span_mask;

   // lowest set bit
   always_comb begin
      pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (free_bits[i]) pos = BIT_W'(i);
      end
   end

   assign hit     = in_range && (|free_bits);
   assign done    = ev_valid_ff && (!in_range || hit);
   assign hit_pos = ev_base_ff + LIM_W'(pos);

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         iss_addr_ff <= '0;
         iss_base_ff <= '0;
         limit_ff    <= limit_in;
      end else if (cmd.scan_run) begin
         iss_addr_ff <= iss_addr_ff + (AW + 1)'(1);
         iss_base_ff <= iss_base_ff + WORD_BITS_L;
         ev_base_ff  <= iss_base_ff;
         if (done) begin
            res_found_ff <= hit;
            res_index_ff <= hit ? hit_pos[IDX_W-1:0] : '0;
         end
      end
   end

   // ---------------- response register ----------------
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_index_ff <= res_index_ff;
         rsp_found_ff <= res_found_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_free_index = rsp_index_ff;
   assign rsp_found      = rsp_found_ff;

   assign status.clear_last = (clr_addr_ff == LAST_WORD);
   assign status.scan_done  = done;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

endmodule

// File: rtl/free_block_bitmap_allocator.sv
// Top level of the first-fit free-block bitmap allocator.
`timescale 1ns / 1ps
// Keeps one allocation bit per block (MAP_BITS bits, WORD_BITS-bit memory words)
// and serves two kinds of request. A toggle flips the bit of block_index and
// returns nothing; blocks at or past MAP_BITS are ignored. A find scans from
// block 0 up for the lowest clear bit below floor(block_count/8)*8 (capped at
// MAP_BITS) and returns free_index with found=1, or 0 with found=0 when there
// is none. After reset a clearing pass zeroes the bitmap one word per cycle,
// MAP_WORDS = ceil(MAP_BITS/WORD_BITS) words in all (1024 at the defaults); no
// request is taken until it ends, register writes are taken throughout.
// After a toggle is accepted, req_ready stays low through the word index
// multiply, memory read and write back. A find reads the words through the
// single memory read port one word per cycle, up to the word holding the
// answer, or on a miss up to the first word at or past the limit. The
// response sits in an output register, so the next request is accepted
// while a response waits. block_count (reset 32768) is written through the
// csr channel, which is always ready; write it only while no request is in
// flight.
module free_block_bitmap_allocator #(
   parameter int MAP_BITS  = fbba_pkg::MAP_BITS_DEF,
   parameter int WORD_BITS = fbba_pkg::WORD_BITS_DEF
) (
   input logic          clock,
   input logic          reset,
   fbba_req_if.sink     req_chan,
   fbba_rsp_if.source   rsp_chan,
   fbba_csr_if.sink     csr_chan
);
   import fbba_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_chan.ready = 1'b1;

   fbba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .req_ready  (req_chan.ready),
      .status     (status),
      .cmd        (cmd)
   );

   fbba_dp #(
      .MAP_BITS  (MAP_BITS),
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_block_index (req_chan.block_index),
      .csr_valid       (csr_chan.valid),
      .csr_block_count (csr_chan.block_count),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_free_index  (rsp_chan.free_index),
      .rsp_found       (rsp_chan.found)
   );

   // a find request occupies the engine: no request is taken right after it
   a_find_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.opcode == OP_FIND) |=> !req_chan.ready)
      else $error("request accepted during a find");

   // a miss reports index zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.found) |-> (rsp_chan.free_index == '0))
      else $error("miss response with nonzero index");

   // the scan stops once its answer is known
   a_scan_stops: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_run && status.scan_done) |=> !cmd.scan_run)
      else $error("scan kept running after completion");

endmodule
